>>> rtl/core/lbbc_pkg.sv
// Shared types and constants for the byte-budget LRU block cache.
package lbbc_pkg;

    localparam int BLK_W      = 16;
    localparam int LINE_W     = 8;
    localparam int BYTES_W    = 24;
    localparam int SLOT_OUT_W = 4;

    localparam logic [BYTES_W-1:0] BUDGET_RESET = BYTES_W'(1024 * 1024);

    // Per-cell command: take the neighbor's entry, or drop the own entry.
    typedef struct packed {
        logic take;
        logic pop;
    } t_cell_ctl;

endpackage

>>> rtl/core/lbbc_cell.sv
// One recency-ordered cell: holds a cached entry and takes its neighbor's entry on a shift.
module lbbc_cell #(
    parameter int SLOT_W = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lbbc_pkg::t_cell_ctl           i_ctl,
    input  logic                          i_prev_valid,
    input  logic [lbbc_pkg::BLK_W-1:0]    i_prev_block,
    input  logic [lbbc_pkg::BYTES_W-1:0]  i_prev_bytes,
    input  logic [SLOT_W-1:0]             i_prev_slot,
    output logic                          o_valid,
    output logic [lbbc_pkg::BLK_W-1:0]    o_block,
    output logic [lbbc_pkg::BYTES_W-1:0]  o_bytes,
    output logic [SLOT_W-1:0]             o_slot
);

    logic                         r_valid;
    logic [lbbc_pkg::BLK_W-1:0]   r_block;
    logic [lbbc_pkg::BYTES_W-1:0] r_bytes;
    logic [SLOT_W-1:0]            r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.take) begin
            r_valid <= i_prev_valid;
        end else if (i_ctl.pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_block <= i_prev_block;
            r_bytes <= i_prev_bytes;
            r_slot  <= i_prev_slot;
        end
    end

    assign o_valid = r_valid;
    assign o_block = r_block;
    assign o_bytes = r_bytes;
    assign o_slot  = r_slot;

endmodule

>>> rtl/core/lbbc_slot_map.sv
// Slot occupancy map with lowest-free-slot search.
module lbbc_slot_map #(
    parameter int N  = 16,
    parameter int SW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_set,
    input  logic [SW-1:0] i_set_slot,
    input  logic          i_clr,
    input  logic [SW-1:0] i_clr_slot,
    output logic [N-1:0]  o_used,
    output logic [SW-1:0] o_free_slot
);

    logic [N-1:0]  r_used;
    logic [N-1:0]  w_free;
    logic [N-1:0]  w_lowest;
    logic [SW-1:0] w_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            if (i_clr) begin
                r_used[i_clr_slot] <= 1'b0;
            end
            if (i_set) begin
                r_used[i_set_slot] <= 1'b1;
            end
        end
    end

    // Isolate the lowest free bit, then encode it.
    assign w_free   = ~r_used;
    assign w_lowest = w_free & (~w_free + N'(1));

    always_comb begin
        w_idx = '0;
        for (int k = 0; k < N; k++) begin
            if (w_lowest[k]) begin
                w_idx = w_idx | SW'(k);
            end
        end
    end

    assign o_used      = r_used;
    assign o_free_slot = w_idx;

endmodule

>>> rtl/core/byte_budget_lru_block_cache_top.sv
// Hit or oversized block: transfer cycle, then a lookup cycle that registers the one result;
// an output stall holds the lookup.
// Miss: lookup, budget evictions one per cycle while the output is free, a step that finds the
// budget met or zeroes bytes on an empty row, then a full-row eviction if needed and the insert.
// One request at a time; the next transfer follows the cycle after the final result registers.
// Synchronous active-low reset empties cells and slot map, zeroes bytes, budget to 1 MiB.
module byte_budget_lru_block_cache_top #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_byte_budget_we,
    input  logic [lbbc_pkg::BYTES_W-1:0]  i_byte_budget,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [lbbc_pkg::BLK_W-1:0]    i_block_id,
    input  logic [lbbc_pkg::LINE_W-1:0]   i_line_index,
    input  logic [lbbc_pkg::BYTES_W-1:0]  i_block_bytes,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit,
    output logic [lbbc_pkg::SLOT_OUT_W-1:0] o_slot,
    output logic [lbbc_pkg::LINE_W-1:0]   o_line_out,
    output logic                          o_is_eviction,
    output logic [lbbc_pkg::BLK_W-1:0]    o_evicted_block,
    output logic                          o_too_big,
    output logic [lbbc_pkg::BYTES_W-1:0]  o_used_total,
    output logic                          o_last
);

    localparam int PW = $clog2(MAX_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EVICT,
        S_PLACE
    } t_state;

    t_state r_state, n_state;

    logic [lbbc_pkg::BLK_W-1:0]   r_blk;
    logic [lbbc_pkg::LINE_W-1:0]  r_line;
    logic [lbbc_pkg::BYTES_W-1:0] r_size;
    logic [lbbc_pkg::BYTES_W-1:0] r_budget;
    logic [lbbc_pkg::BYTES_W-1:0] r_used, n_used;

    logic                           r_out_valid;
    logic                           r_hit;
    logic [lbbc_pkg::SLOT_OUT_W-1:0] r_slot;
    logic [lbbc_pkg::LINE_W-1:0]    r_line_out;
    logic                           r_evict;
    logic [lbbc_pkg::BLK_W-1:0]     r_ev_blk;
    logic                           r_too_big;
    logic [lbbc_pkg::BYTES_W-1:0]   r_used_total;
    logic                           r_last;

    // Cell row
    logic [MAX_ENTRIES-1:0]       w_valid;
    logic [lbbc_pkg::BLK_W-1:0]   w_blk   [MAX_ENTRIES];
    logic [lbbc_pkg::BYTES_W-1:0] w_bytes [MAX_ENTRIES];
    logic [PW-1:0]                w_slot  [MAX_ENTRIES];
    lbbc_pkg::t_cell_ctl          w_ctl   [MAX_ENTRIES];

    logic [MAX_ENTRIES-1:0]       w_match;
    logic [MAX_ENTRIES-1:0]       w_last_oh;
    logic                         w_hit_any;
    logic [PW-1:0]                w_hit_pos;
    logic [PW-1:0]                w_hit_slot;
    logic [lbbc_pkg::BYTES_W-1:0] w_hit_bytes;
    logic [PW-1:0]                w_old_slot;
    logic [lbbc_pkg::BLK_W-1:0]   w_old_blk;
    logic [lbbc_pkg::BYTES_W-1:0] w_old_bytes;

    logic [MAX_ENTRIES-1:0]       w_used_map;
    logic [PW-1:0]                w_free_slot;

    logic [lbbc_pkg::BYTES_W-1:0] w_head_bytes;
    logic [PW-1:0]                w_head_slot;

    logic w_out_free, w_over, w_big, w_full, w_any;
    logic w_do_hit, w_do_big, w_do_evict, w_do_insert, w_do_zero, w_emit;
    logic [PW-1:0] w_emit_slot;

    assign w_head_bytes = w_do_hit ? w_hit_bytes : r_size;
    assign w_head_slot  = w_do_hit ? w_hit_slot  : w_free_slot;

    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        if (k == 0) begin : g_head
            lbbc_cell #(.SLOT_W(PW)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl[k]),
                .i_prev_valid (1'b1),
                .i_prev_block (r_blk),
                .i_prev_bytes (w_head_bytes),
                .i_prev_slot  (w_head_slot),
                .o_valid      (w_valid[k]),
                .o_block      (w_blk[k]),
                .o_bytes      (w_bytes[k]),
                .o_slot       (w_slot[k])
            );
        end else begin : g_body
            lbbc_cell #(.SLOT_W(PW)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl[k]),
                .i_prev_valid (w_valid[k-1]),
                .i_prev_block (w_blk[k-1]),
                .i_prev_bytes (w_bytes[k-1]),
                .i_prev_slot  (w_slot[k-1]),
                .o_valid      (w_valid[k]),
                .o_block      (w_blk[k]),
                .o_bytes      (w_bytes[k]),
                .o_slot       (w_slot[k])
            );
        end
        // Move to front shifts every cell down to the hit position.
        assign w_ctl[k].take = w_do_insert || (w_do_hit && (PW'(k) <= w_hit_pos));
        assign w_ctl[k].pop  = w_do_evict && w_last_oh[k];
    end

    lbbc_slot_map #(.N(MAX_ENTRIES), .SW(PW)) u_slot_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_set       (w_do_insert),
        .i_set_slot  (w_free_slot),
        .i_clr       (w_do_evict),
        .i_clr_slot  (w_old_slot),
        .o_used      (w_used_map),
        .o_free_slot (w_free_slot)
    );

    // Valid cells form a prefix; the oldest entry sits in the last valid cell.
    assign w_last_oh = w_valid & ~(w_valid >> 1);

    always_comb begin
        w_hit_pos   = '0;
        w_hit_slot  = '0;
        w_hit_bytes = '0;
        w_old_slot  = '0;
        w_old_blk   = '0;
        w_old_bytes = '0;
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            w_match[k] = w_valid[k] && (w_blk[k] == r_blk);
            if (w_match[k]) begin
                w_hit_pos   = w_hit_pos   | PW'(k);
                w_hit_slot  = w_hit_slot  | w_slot[k];
                w_hit_bytes = w_hit_bytes | w_bytes[k];
            end
            if (w_last_oh[k]) begin
                w_old_slot  = w_old_slot  | w_slot[k];
                w_old_blk   = w_old_blk   | w_blk[k];
                w_old_bytes = w_old_bytes | w_bytes[k];
            end
        end
    end

    assign w_hit_any  = |w_match;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_over     = ({1'b0, r_used} + {1'b0, r_size}) > {1'b0, r_budget};
    assign w_big      = r_size > r_budget;
    assign w_full     = w_valid[MAX_ENTRIES-1];
    assign w_any      = w_valid[0];

    always_comb begin
        n_state     = r_state;
        w_do_hit    = 1'b0;
        w_do_big    = 1'b0;
        w_do_evict  = 1'b0;
        w_do_insert = 1'b0;
        w_do_zero   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (w_out_free) begin
                    if (w_hit_any) begin
                        w_do_hit = 1'b1;
                        n_state  = S_IDLE;
                    end else if (w_big) begin
                        w_do_big = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_EVICT;
                    end
                end
            end
            S_EVICT: begin
                if (!w_over) begin
                    n_state = S_PLACE;
                end else if (!w_any) begin
                    w_do_zero = 1'b1;
                    n_state   = S_PLACE;
                end else if (w_out_free) begin
                    w_do_evict = 1'b1;
                end
            end
            S_PLACE: begin
                // A full row drops its oldest entry first, freeing that slot.
                if (w_out_free) begin
                    if (w_full) begin
                        w_do_evict = 1'b1;
                    end else begin
                        w_do_insert = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_do_evict) begin
            n_used = (r_used >= w_old_bytes) ? (r_used - w_old_bytes) : '0;
        end else if (w_do_insert) begin
            n_used = r_used + r_size;
        end else if (w_do_zero) begin
            n_used = '0;
        end else begin
            n_used = r_used;
        end
    end

    assign w_emit = w_do_hit || w_do_big || w_do_evict || w_do_insert;

    always_comb begin
        if (w_do_hit) begin
            w_emit_slot = w_hit_slot;
        end else if (w_do_evict) begin
            w_emit_slot = w_old_slot;
        end else if (w_do_insert) begin
            w_emit_slot = w_free_slot;
        end else begin
            w_emit_slot = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_budget    <= lbbc_pkg::BUDGET_RESET;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            if (i_byte_budget_we) begin
                r_budget <= i_byte_budget;
            end
            if (r_state == S_IDLE && i_valid) begin
                r_blk  <= i_block_id;
                r_line <= i_line_index;
                r_size <= i_block_bytes;
            end
            if (w_emit) begin
                r_out_valid  <= 1'b1;
                r_hit        <= w_do_hit;
                r_slot       <= lbbc_pkg::SLOT_OUT_W'(w_emit_slot);
                r_line_out   <= r_line;
                r_evict      <= w_do_evict;
                r_ev_blk     <= w_do_evict ? w_old_blk : '0;
                r_too_big    <= w_do_big;
                r_used_total <= n_used;
                r_last       <= w_do_hit || w_do_big || w_do_insert;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_hit           = r_hit;
    assign o_slot          = r_slot;
    assign o_line_out      = r_line_out;
    assign o_is_eviction   = r_evict;
    assign o_evicted_block = r_ev_blk;
    assign o_too_big       = r_too_big;
    assign o_used_total    = r_used_total;
    assign o_last          = r_last;

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + MAX_ENTRIES'(1))) == '0)
        else $error("cell row valid bits are not a prefix");

    a_map_matches_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_used_map) == $countones(w_valid))
        else $error("slot map occupancy disagrees with cell row");

    a_partial_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (r_state != S_IDLE))
        else $error("non-final result pending while idle");

    a_evict_has_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_evict |-> w_any)
        else $error("eviction with an empty cell row");

endmodule
